>>> hdl/sgme_pkg.sv
// ----------------------------------------------------------------------------
// sgme_pkg: shared types and constants of the spin glass Metropolis engine
// Lattice geometry, queue item layout, mode codes and the exponential table.
// ----------------------------------------------------------------------------
package sgme_pkg;

  localparam int LATTICE_X       = 64;
  localparam int LATTICE_Y       = 64;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int COUPLING_BITS   = 16;

  localparam int SITES   = LATTICE_X * LATTICE_Y;
  localparam int SITE_W  = $clog2(SITES);
  localparam int X_W     = $clog2(LATTICE_X);
  localparam int Y_W     = $clog2(LATTICE_Y);
  localparam int K_W     = $clog2(EXP_TABLE_DEPTH);
  localparam int BOND_W  = (COUPLING_BITS < 16) ? COUPLING_BITS : 16;
  localparam int EXP_SHIFT = 26;
  localparam logic [63:0] EXP_RATIO = 64'd4228380000;

  localparam int DE_W  = 36;
  localparam int EN_W  = 48;
  localparam int MAG_W = 14;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    MODE_BONDS = 2'd0,
    MODE_SPIN  = 2'd1,
    MODE_FLIP  = 2'd2,
    MODE_SWEEP = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_SCALE = 1'b0,
    REG_ITEMP = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SUM, ST_MUL, ST_KMUL, ST_KSUM, ST_ROM,
    ST_DECIDE, ST_WB, ST_SW_RD, ST_SW_T, ST_SW_M, ST_SW_ACC, ST_SW_END, ST_RESP
  } state_t;

  typedef struct packed {
    mode_t             mode;
    logic [SITE_W-1:0] here;
    logic [SITE_W-1:0] xm;
    logic [SITE_W-1:0] xp;
    logic [SITE_W-1:0] ym;
    logic [SITE_W-1:0] yp;
    logic              spin;
    logic [15:0]       vc;
    logic [15:0]       hc;
    logic [15:0]       u;
  } q_item_t;

  typedef struct packed {
    logic             flipped;
    logic             spin_now;
    logic [DE_W-1:0]  delta_energy;
    logic [EN_W-1:0]  energy_total;
    logic [MAG_W-1:0] magnet_total;
  } result_t;

  typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];
  typedef logic [X_W-1:0] xmod_t [64];
  typedef logic [Y_W-1:0] ymod_t [64];

  function automatic exp_rom_t gen_exp_rom();
    exp_rom_t    rom;
    logic [63:0] p;
    logic [63:0] r;
    p = 64'd1 << 32;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      r = (p + 64'd32768) >> 16;
      rom[k] = r[16:0];
      p = (p * EXP_RATIO + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  function automatic xmod_t gen_xmod();
    xmod_t t;
    for (int v = 0; v < 64; v++) t[v] = X_W'(v % LATTICE_X);
    return t;
  endfunction

  function automatic ymod_t gen_ymod();
    ymod_t t;
    for (int v = 0; v < 64; v++) t[v] = Y_W'(v % LATTICE_Y);
    return t;
  endfunction

  function automatic logic [SITE_W-1:0] site_of(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    return SITE_W'(x) * SITE_W'(LATTICE_Y) + SITE_W'(y);
  endfunction

endpackage

>>> hdl/sgme_front.sv
// ----------------------------------------------------------------------------
// sgme_front: input decode
// Folds positions onto the lattice and works out the site and its neighbors.
// ----------------------------------------------------------------------------
module sgme_front
  import sgme_pkg::*;
(
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [IN_TDATA_W-1:0] in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output q_item_t               q_item
);

  localparam xmod_t XMOD = gen_xmod();
  localparam ymod_t YMOD = gen_ymod();

  logic [X_W-1:0] x, xm, xp;
  logic [Y_W-1:0] y, ym, yp;

  assign x  = XMOD[in_data[5:0]];
  assign y  = YMOD[in_data[11:6]];
  assign xm = (x == '0) ? X_W'(LATTICE_X - 1) : x - X_W'(1);
  assign xp = (x == X_W'(LATTICE_X - 1)) ? '0 : x + X_W'(1);
  assign ym = (y == '0) ? Y_W'(LATTICE_Y - 1) : y - Y_W'(1);
  assign yp = (y == Y_W'(LATTICE_Y - 1)) ? '0 : y + Y_W'(1);

  always_comb begin
    q_item.mode = mode_t'(in_mode);
    q_item.here = site_of(x, y);
    q_item.xm   = site_of(xm, y);
    q_item.xp   = site_of(xp, y);
    q_item.ym   = site_of(x, ym);
    q_item.yp   = site_of(x, yp);
    q_item.spin = in_data[12];
    q_item.vc   = in_data[28:13];
    q_item.hc   = in_data[44:29];
    q_item.u    = in_data[60:45];
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

>>> hdl/sgme_queue.sv
// ----------------------------------------------------------------------------
// sgme_queue: two-entry command queue
// Parts the front decode from the back execution unit.
// ----------------------------------------------------------------------------
module sgme_queue
  import sgme_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output q_item_t head
);

  q_item_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

>>> hdl/sgme_back.sv
// ----------------------------------------------------------------------------
// sgme_back: execution unit
// Owns the lattice memories, runs loads, Metropolis attempts and sweeps.
// ----------------------------------------------------------------------------
module sgme_back
  import sgme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] coupling_scale,
  input  logic [15:0] inv_temp,
  input  logic        q_empty,
  input  q_item_t     q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int SUM_W = BOND_W + 3;
  localparam int T_W   = BOND_W + 2;
  localparam int ACC_W = 49 + SITE_W;
  localparam exp_rom_t EXP_ROM = gen_exp_rom();
  localparam logic signed [BOND_W-1:0] BOND_RST = BOND_W'(4096);
  localparam logic signed [47:0] E_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] E_MIN = {1'b1, {47{1'b0}}};

  // lattice memories
  logic                     spin_mem [SITES];
  logic signed [BOND_W-1:0] vb_mem   [SITES];
  logic signed [BOND_W-1:0] hb_mem   [SITES];

  state_t state_r, state_nxt;
  q_item_t cmd_r;
  logic [2:0]        cnt_r;
  logic [SITE_W-1:0] clr_cnt_r;
  logic [X_W-1:0]    i_r, ip;
  logic [Y_W-1:0]    j_r, jp;

  logic [SITE_W-1:0]        rd_addr, wr_addr;
  logic                     rd_spin_q;
  logic signed [BOND_W-1:0] rd_vb_q, rd_hb_q;
  logic                     spin_we, bond_we, spin_wd;
  logic signed [BOND_W-1:0] vb_wd, hb_wd;

  logic s_r, sxm_r, sxp_r, sym_r, syp_r;
  logic signed [BOND_W-1:0] vh_r, hh_r, vxm_r, hym_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DE_W-1:0]   de_r;
  logic [33:0]              pl_r, ph_r;
  logic                     krange_r, accept_r;
  logic [K_W-1:0]           kidx_r;
  logic [16:0]              rom_q_r;
  logic signed [T_W-1:0]    t_r;
  logic signed [T_W+16:0]   term_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [EN_W-1:0]   energy_r;
  logic signed [MAG_W-1:0]  magnet_r;
  logic                     res_flip_r, res_spin_r;
  logic signed [DE_W-1:0]   res_de_r;
  logic                     out_valid_r;
  result_t                  out_r;

  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W+16:0] prod_c;
  logic signed [SUM_W+17:0] de2_c;
  logic [51:0]              kp_c;
  logic [25:0]              kf_c;
  logic signed [T_W-1:0]    t_c;
  logic signed [48:0]       esum_c;
  logic signed [EN_W-1:0]   eadd_c, eacc_c;
  logic                     last_site, resp_load;

  assign ip = (i_r == X_W'(LATTICE_X - 1)) ? '0 : i_r + X_W'(1);
  assign jp = (j_r == Y_W'(LATTICE_Y - 1)) ? '0 : j_r + Y_W'(1);
  assign last_site = (i_r == X_W'(LATTICE_X - 1)) && (j_r == Y_W'(LATTICE_Y - 1));

  assign sum_c = (sxm_r ? SUM_W'(vxm_r) : -SUM_W'(vxm_r))
               + (sxp_r ? SUM_W'(vh_r)  : -SUM_W'(vh_r))
               + (sym_r ? SUM_W'(hym_r) : -SUM_W'(hym_r))
               + (syp_r ? SUM_W'(hh_r)  : -SUM_W'(hh_r));
  assign prod_c = sum_r * $signed({1'b0, coupling_scale});
  assign de2_c  = {prod_c, 1'b0};
  assign kp_c   = {ph_r, 18'b0} + 52'(pl_r);
  assign kf_c   = kp_c[51:26];
  assign t_c    = (sxp_r ? T_W'(hym_r) : -T_W'(hym_r))
                + (syp_r ? T_W'(vxm_r) : -T_W'(vxm_r));

  assign esum_c = 49'(energy_r) + 49'(de_r);
  assign eadd_c = (esum_c[48] != esum_c[47]) ? (esum_c[48] ? E_MIN : E_MAX) : esum_c[47:0];
  assign eacc_c = (acc_r > ACC_W'(E_MAX)) ? E_MAX :
                  (acc_r < ACC_W'(E_MIN)) ? E_MIN : acc_r[47:0];

  assign resp_load = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  // memory ports
  always_ff @(posedge clk) begin
    rd_spin_q <= spin_mem[rd_addr];
    rd_vb_q   <= vb_mem[rd_addr];
    rd_hb_q   <= hb_mem[rd_addr];
    if (spin_we) spin_mem[wr_addr] <= spin_wd;
    if (bond_we) begin
      vb_mem[wr_addr] <= vb_wd;
      hb_mem[wr_addr] <= hb_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    rd_addr   = cmd_r.here;
    wr_addr   = cmd_r.here;
    spin_we   = 1'b0;
    bond_we   = 1'b0;
    spin_wd   = 1'b1;
    vb_wd     = cmd_r.vc[BOND_W-1:0];
    hb_wd     = cmd_r.hc[BOND_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        wr_addr = clr_cnt_r;
        spin_we = 1'b1;
        bond_we = 1'b1;
        vb_wd   = BOND_RST;
        hb_wd   = BOND_RST;
        if (clr_cnt_r == SITE_W'(SITES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        case (cnt_r)
          3'd0:    rd_addr = cmd_r.here;
          3'd1:    rd_addr = cmd_r.xm;
          3'd2:    rd_addr = cmd_r.xp;
          3'd3:    rd_addr = cmd_r.ym;
          default: rd_addr = cmd_r.yp;
        endcase
        if (cmd_r.mode == MODE_FLIP) begin
          if (cnt_r == 3'd5) state_nxt = ST_SUM;
        end else if (cnt_r == 3'd1) begin
          state_nxt = (cmd_r.mode == MODE_SWEEP) ? ST_SW_RD : ST_WB;
        end
      end
      ST_SUM:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_KMUL;
      ST_KMUL:   state_nxt = ST_KSUM;
      ST_KSUM:   state_nxt = ST_ROM;
      ST_ROM:    state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_WB;
      ST_WB: begin
        case (cmd_r.mode)
          MODE_BONDS: bond_we = 1'b1;
          MODE_SPIN: begin
            spin_we = (cmd_r.spin != s_r);
            spin_wd = cmd_r.spin;
          end
          MODE_FLIP: begin
            spin_we = accept_r;
            spin_wd = !s_r;
          end
          default: ;
        endcase
        state_nxt = ST_RESP;
      end
      ST_SW_RD: begin
        case (cnt_r)
          3'd0:    rd_addr = site_of(i_r, j_r);
          3'd1:    rd_addr = site_of(i_r, jp);
          default: rd_addr = site_of(ip, j_r);
        endcase
        if (cnt_r == 3'd3) state_nxt = ST_SW_T;
      end
      ST_SW_T:   state_nxt = ST_SW_M;
      ST_SW_M:   state_nxt = ST_SW_ACC;
      ST_SW_ACC: state_nxt = last_site ? ST_SW_END : ST_SW_RD;
      ST_SW_END: state_nxt = ST_RESP;
      ST_RESP:   if (resp_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r <= q_head;
        cnt_r <= 3'd0;
      end
      ST_READ: begin
        cnt_r <= cnt_r + 3'd1;
        case (cnt_r)
          3'd1: begin
            s_r  <= rd_spin_q;
            vh_r <= rd_vb_q;
            hh_r <= rd_hb_q;
          end
          3'd2: begin
            sxm_r <= rd_spin_q;
            vxm_r <= rd_vb_q;
          end
          3'd3: sxp_r <= rd_spin_q;
          3'd4: begin
            sym_r <= rd_spin_q;
            hym_r <= rd_hb_q;
          end
          3'd5: syp_r <= rd_spin_q;
          default: ;
        endcase
        if (cmd_r.mode == MODE_SWEEP && cnt_r == 3'd1) begin
          cnt_r <= 3'd0;
          i_r   <= '0;
          j_r   <= '0;
          acc_r <= '0;
        end
      end
      ST_SUM:  sum_r <= sum_c;
      ST_MUL:  de_r <= s_r ? de2_c[DE_W-1:0] : -de2_c[DE_W-1:0];
      ST_KMUL: begin
        pl_r <= de_r[17:0] * inv_temp;
        ph_r <= de_r[35:18] * inv_temp;
      end
      ST_KSUM: begin
        krange_r <= (kf_c < 26'(EXP_TABLE_DEPTH));
        kidx_r   <= kf_c[K_W-1:0];
      end
      ST_ROM:    rom_q_r <= EXP_ROM[kidx_r];
      ST_DECIDE: accept_r <= (de_r <= 0) || (krange_r && ({1'b0, cmd_r.u} < rom_q_r));
      ST_WB: begin
        res_flip_r <= 1'b0;
        res_spin_r <= s_r;
        res_de_r   <= '0;
        case (cmd_r.mode)
          MODE_SPIN: begin
            res_spin_r <= cmd_r.spin;
            if (cmd_r.spin != s_r)
              magnet_r <= magnet_r + (cmd_r.spin ? MAG_W'(2) : -MAG_W'(2));
          end
          MODE_FLIP: begin
            res_de_r <= de_r;
            if (accept_r) begin
              res_flip_r <= 1'b1;
              res_spin_r <= !s_r;
              magnet_r   <= magnet_r + (s_r ? -MAG_W'(2) : MAG_W'(2));
              energy_r   <= eadd_c;
            end
          end
          default: ;
        endcase
      end
      ST_SW_RD: begin
        cnt_r <= cnt_r + 3'd1;
        case (cnt_r)
          3'd1: begin
            sxm_r <= rd_spin_q;
            vxm_r <= rd_vb_q;
            hym_r <= rd_hb_q;
          end
          3'd2: sxp_r <= rd_spin_q;
          3'd3: syp_r <= rd_spin_q;
          default: ;
        endcase
      end
      ST_SW_T: t_r <= sxm_r ? t_c : -t_c;
      ST_SW_M: term_r <= t_r * $signed({1'b0, coupling_scale});
      ST_SW_ACC: begin
        acc_r <= acc_r - ACC_W'(term_r);
        cnt_r <= 3'd0;
        j_r   <= jp;
        if (j_r == Y_W'(LATTICE_Y - 1)) i_r <= ip;
      end
      ST_SW_END: begin
        energy_r   <= eacc_c;
        res_flip_r <= 1'b0;
        res_spin_r <= s_r;
        res_de_r   <= '0;
      end
      default: ;
    endcase
    if (resp_load) begin
      out_r.flipped      <= res_flip_r;
      out_r.spin_now     <= res_spin_r;
      out_r.delta_energy <= res_de_r;
      out_r.energy_total <= energy_r;
      out_r.magnet_total <= magnet_r;
    end
    if (!rst_n) begin
      energy_r <= '0;
      magnet_r <= MAG_W'(SITES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + SITE_W'(1);
      if (resp_load)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> hdl/spin_glass_metropolis_engine.sv
// ----------------------------------------------------------------------------
// spin_glass_metropolis_engine: Ising spin glass Metropolis update engine
// Periodic lattice of spins and bonds with running energy and magnetization.
// ----------------------------------------------------------------------------
// channel  | signals              | role
// in_      | tvalid tready tdata  | command item, mode in tuser
//          | tuser                |
// out_     | tvalid tready tdata  | one result per command
// cfg_     | APB                  | coupling_scale (0x0), inv_temp (0x4)
//
// A Metropolis attempt runs five reads through the single lattice memory port,
// two multiplier stages and a registered exponential table read. An energy
// sweep runs three reads and an accumulate per site. After reset a clearing
// pass over all SITES (4096) sites loads the lattice; the back end takes no
// command from the queue meanwhile. The queue keeps taking commands while the
// back end works or the output stalls, until its two entries are full; then
// in_tready drops.
// ----------------------------------------------------------------------------
module spin_glass_metropolis_engine
  import sgme_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [5:0] x_pos, [11:6] y_pos, [12] spin_in, [28:13] vert_coupling,
  // [44:29] horiz_coupling, [60:45] random_u
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] flipped, [1] spin_now, [37:2] delta_energy, [85:38] energy_total,
  // [99:86] magnet_total
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [15:0] scale_r, itemp_r;
  logic        q_push, q_full, q_pop, q_empty;
  q_item_t     q_item, q_head;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx_t'(cfg_paddr[2]) == REG_ITEMP) ? {16'b0, itemp_r}
                                                               : {16'b0, scale_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd4096;
      itemp_r <= 16'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx_t'(cfg_paddr[2]))
        REG_SCALE: scale_r <= cfg_pwdata[15:0];
        REG_ITEMP: itemp_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  sgme_front u_front (
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_data  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  sgme_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sgme_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .coupling_scale (scale_r),
    .inv_temp       (itemp_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_res        (res)
  );

  assign out_tdata = {4'b0, res.magnet_total, res.energy_total, res.delta_energy,
                      res.spin_now, res.flipped};

endmodule

>>> hdl/sgme_checker.sv
// ----------------------------------------------------------------------------
// sgme_checker: port-level checks of the engine
// Output handshake rules and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module sgme_checker
  import sgme_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a negative energy change is always taken
  a_neg_flips: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[37] |-> out_tdata[0])
    else $error("negative delta_energy without flip");

  // a result without a flip never carries a negative energy change
  a_flip_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> !out_tdata[37])
    else $error("rejected attempt with negative delta_energy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result right after reset");

endmodule

bind spin_glass_metropolis_engine sgme_checker u_sgme_checker (.*);
